// ----- rtl/rcfd_pkg.sv -----
// rcfd_pkg: shared types and constants for the remote control frame decoder
// used by rcfd_front, rcfd_queue, rcfd_back and the top level; no dependencies
package rcfd_pkg;

    // frame and field sizes
    localparam int FRAME_BYTES_DEF = 18;
    localparam int CHAN_W          = 11;
    localparam int SW_W            = 2;
    localparam int TICK_W          = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAN_W-1:0] CHAN_DEFAULT = 11'd1024;
    localparam logic [TICK_W-1:0] TICK_MAX     = 16'hffff;

    // configuration register indexes
    localparam logic [1:0] CFG_CHANNEL_MIN = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_MAX = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [CHAN_W-1:0] CHANNEL_MIN_RST = 11'd364;
    localparam logic [CHAN_W-1:0] CHANNEL_MAX_RST = 11'd1684;
    localparam logic [TICK_W-1:0] TIMEOUT_RST     = 16'd100;

    // input command codes as seen on the stream
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_EOF   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_EOF   = 2'd1,
        OP_TICK  = 2'd2,
        OP_START = 2'd3
    } t_op;

    // link status, also the back end state machine
    typedef enum logic [1:0] {
        LINK_IDLE    = 2'd0,
        LINK_RUNNING = 2'd1,
        LINK_TIMEOUT = 2'd2,
        LINK_ERROR   = 2'd3
    } t_link;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [SW_W-1:0]   right_switch;
        logic [SW_W-1:0]   left_switch;
        logic [CHAN_W-1:0] dial_value;
        logic [CHAN_W-1:0] left_y;
        logic [CHAN_W-1:0] left_x;
        logic [CHAN_W-1:0] right_y;
        logic [CHAN_W-1:0] right_x;
        logic              data_valid;
        t_link             link_status;
    } t_result;

endpackage

// ----- rtl/rcfd_front.sv -----
// rcfd_front: accepts stream requests and classifies the command code
// depends on rcfd_pkg
module rcfd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rcfd_pkg::t_item      o_item
);
    import rcfd_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // command code to operation
    always_comb begin
        n_item.rx_byte = i_rx_byte;
        case (i_command)
            CMD_BYTE:  n_item.op = OP_BYTE;
            CMD_EOF:   n_item.op = OP_EOF;
            CMD_TICK:  n_item.op = OP_TICK;
            CMD_START: n_item.op = OP_START;
            default:   n_item.op = OP_BYTE;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // holding register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ----- rtl/rcfd_queue.sv -----
// rcfd_queue: short fifo of classified requests between front and back
// depends on rcfd_pkg
module rcfd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  rcfd_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output rcfd_pkg::t_item o_item
);
    import rcfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_ready = (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/rcfd_back.sv -----
// rcfd_back: frame store, channel unpack and check, link state, tick timer,
// configuration registers and the output register; depends on rcfd_pkg
module rcfd_back #(
    parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rcfd_pkg::t_cfg_wr i_cfg,
    input  logic              i_valid,
    output logic              o_pop,
    input  rcfd_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output rcfd_pkg::t_result o_result
);
    import rcfd_pkg::*;

    localparam int IDX_W  = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(FRAME_BYTES);

    // configuration
    logic [CHAN_W-1:0] r_ch_min;
    logic [CHAN_W-1:0] r_ch_max;
    logic [TICK_W-1:0] r_timeout;

    // datapath state
    logic [7:0]        r_store [FRAME_BYTES];
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    t_link             r_link;
    t_link             n_link;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] n_elapsed;
    logic [CHAN_W-1:0] r_ch [5];
    logic [CHAN_W-1:0] n_ch [5];
    logic [SW_W-1:0]   r_sw_left;
    logic [SW_W-1:0]   r_sw_right;
    logic [SW_W-1:0]   n_sw_left;
    logic [SW_W-1:0]   n_sw_right;

    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              step;
    logic              store_wr;
    logic              started;
    logic              frame_good;
    logic [CHAN_W-1:0] dec_ch [5];
    logic [TICK_W-1:0] tick_inc;
    logic              tick_over;

    assign step    = i_valid && (!r_out_valid || i_ready);
    assign o_pop   = step;
    assign started = (r_link != LINK_IDLE);

    // unpack the five channels from the stored bytes
    always_comb begin
        dec_ch[0] = {r_store[1][2:0], r_store[0]};
        dec_ch[1] = {r_store[2][5:0], r_store[1][7:3]};
        dec_ch[2] = {r_store[4][0], r_store[3], r_store[2][7:6]};
        dec_ch[3] = {r_store[5][3:0], r_store[4][7:1]};
        dec_ch[4] = {r_store[17][2:0], r_store[16]};
    end

    // inclusive window check on every channel
    always_comb begin
        frame_good = 1'b1;
        for (int k = 0; k < 5; k++) begin
            if (dec_ch[k] < r_ch_min || dec_ch[k] > r_ch_max) begin
                frame_good = 1'b0;
            end
        end
    end

    // saturating tick count and timeout compare
    assign tick_inc  = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign tick_over = (tick_inc > r_timeout);

    // next link state
    always_comb begin
        n_link = r_link;
        case (i_item.op)
            OP_BYTE: n_link = r_link;
            OP_EOF: begin
                if (started) begin
                    n_link = frame_good ? LINK_RUNNING : LINK_ERROR;
                end
            end
            OP_TICK: begin
                if (started && tick_over) begin
                    n_link = LINK_TIMEOUT;
                end
            end
            OP_START: n_link = LINK_RUNNING;
            default:  n_link = r_link;
        endcase
    end

    // datapath next values driven by the operation
    always_comb begin
        n_idx      = r_idx;
        n_elapsed  = r_elapsed;
        n_sw_left  = r_sw_left;
        n_sw_right = r_sw_right;
        store_wr   = 1'b0;
        for (int k = 0; k < 5; k++) begin
            n_ch[k] = r_ch[k];
        end
        case (i_item.op)
            OP_BYTE: begin
                if (started && r_idx < IDX_W'(FRAME_BYTES)) begin
                    store_wr = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end
            end
            OP_EOF: begin
                if (started) begin
                    n_idx = '0;
                    if (frame_good) begin
                        for (int k = 0; k < 5; k++) begin
                            n_ch[k] = dec_ch[k];
                        end
                        n_sw_left  = r_store[5][7:6];
                        n_sw_right = r_store[5][5:4];
                        n_elapsed  = '0;
                    end else begin
                        for (int k = 0; k < 5; k++) begin
                            n_ch[k] = CHAN_DEFAULT;
                        end
                        n_sw_left  = '0;
                        n_sw_right = '0;
                    end
                end
            end
            OP_TICK: begin
                n_elapsed = tick_inc;
                if (started && tick_over) begin
                    for (int k = 0; k < 5; k++) begin
                        n_ch[k] = CHAN_DEFAULT;
                    end
                    n_sw_left  = '0;
                    n_sw_right = '0;
                    n_idx      = '0;
                end
            end
            OP_START: n_idx = '0;
            default:  n_idx = r_idx;
        endcase
    end

    // result fields from the state after the request
    always_comb begin
        n_out.link_status  = n_link;
        n_out.data_valid   = (n_link == LINK_RUNNING);
        n_out.right_x      = n_ch[0];
        n_out.right_y      = n_ch[1];
        n_out.left_x       = n_ch[2];
        n_out.left_y       = n_ch[3];
        n_out.dial_value   = n_ch[4];
        n_out.left_switch  = n_sw_left;
        n_out.right_switch = n_sw_right;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_min  <= CHANNEL_MIN_RST;
            r_ch_max  <= CHANNEL_MAX_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CHANNEL_MIN: r_ch_min  <= i_cfg.data[CHAN_W-1:0];
                CFG_CHANNEL_MAX: r_ch_max  <= i_cfg.data[CHAN_W-1:0];
                CFG_TIMEOUT:     r_timeout <= i_cfg.data;
                default:         r_timeout <= r_timeout;
            endcase
        end
    end

    // frame store, written one byte per data request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < FRAME_BYTES; k++) begin
                r_store[k] <= '0;
            end
        end else if (step && store_wr) begin
            r_store[r_idx[ADDR_W-1:0]] <= i_item.rx_byte;
        end
    end

    // link state and decoded data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link     <= LINK_IDLE;
            r_idx      <= '0;
            r_elapsed  <= '0;
            r_sw_left  <= '0;
            r_sw_right <= '0;
            for (int k = 0; k < 5; k++) begin
                r_ch[k] <= CHAN_DEFAULT;
            end
        end else if (step) begin
            r_link     <= n_link;
            r_idx      <= n_idx;
            r_elapsed  <= n_elapsed;
            r_sw_left  <= n_sw_left;
            r_sw_right <= n_sw_right;
            for (int k = 0; k < 5; k++) begin
                r_ch[k] <= n_ch[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- rtl/rc_receiver_frame_decoder_top.sv -----
// rc_receiver_frame_decoder_top: stream ports, front, queue and back end
// depends on rcfd_pkg, rcfd_front, rcfd_queue, rcfd_back
//
// Usage:
//   Slave stream carries one request per transfer: tuser holds the command
//   (data byte, end of frame, tick, start) and tdata the received byte.
//   Master stream returns exactly one result per request, in order: tuser
//   holds link status and data valid, tdata the five channels and switches.
//   A separate write channel (index, data) sets channel_min, channel_max
//   and timeout_ticks; it is always ready and is meant for idle periods.
//   A request passes the front register, the queue and the back end output
//   register, in that order, before its result is offered on the master
//   stream. Throughput: one request per cycle sustained while the master
//   stream takes results; the frame unpack and the five window compares
//   are combinational in the back end.
//   Reset clears the queue, the frame store, link state (not started),
//   tick count and the channels to 1024, switches to 0.
//   When the master side stalls, the output register holds, the back end
//   stops, the queue then the front register fill, then slave tready drops.
module rc_receiver_frame_decoder_top #(
    parameter int FRAME_BYTES = rcfd_pkg::FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [10:0] right_x, [21:11] right_y, [32:22] left_x, [43:33] left_y,
    // [54:44] dial_value, [56:55] left_switch, [58:57] right_switch, rest 0
    output logic [63:0] o_m_tdata,
    output logic [2:0]  o_m_tuser,   // [1:0] link_status, [2] data_valid
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);
    import rcfd_pkg::*;

    logic     fr_valid;
    logic     q_ready;
    t_item    fr_item;
    logic     q_valid;
    logic     q_pop;
    t_item    q_item;
    t_cfg_wr  cfg_wr;
    t_result  res;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_addr;
    assign cfg_wr.data  = i_cfg_data;

    rcfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_command (i_s_tuser),
        .i_rx_byte (i_s_tdata),
        .o_valid   (fr_valid),
        .i_ready   (q_ready),
        .o_item    (fr_item)
    );

    rcfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .o_ready (q_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    rcfd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_item   (q_item),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (res)
    );

    // pack result fields onto the master stream
    assign o_m_tuser = {res.data_valid, res.link_status};
    assign o_m_tdata = {5'd0, res.right_switch, res.left_switch, res.dial_value,
                        res.left_y, res.left_x, res.right_y, res.right_x};

endmodule
